/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared modes, token kinds, character codes and classifier functions.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned MAX_RECS     = 6;
  localparam int unsigned CNT_BITS     = 3;

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_COMMENT    = 4'd2,
    MODE_IDENT      = 4'd3,
    MODE_INT        = 4'd4,
    MODE_FLOAT      = 4'd5,
    MODE_STRING     = 4'd6,
    MODE_CHAR_OPEN  = 4'd7,
    MODE_CHAR_CLOSE = 4'd8,
    MODE_OP2        = 4'd9
  } mode_e;

  localparam logic [5:0] KIND_IDENT     = 6'd0;
  localparam logic [5:0] KIND_INT       = 6'd1;
  localparam logic [5:0] KIND_FLOAT     = 6'd2;
  localparam logic [5:0] KIND_STRING    = 6'd3;
  localparam logic [5:0] KIND_CHAR      = 6'd4;
  localparam logic [5:0] KIND_PLUS      = 6'd5;
  localparam logic [5:0] KIND_MINUS     = 6'd6;
  localparam logic [5:0] KIND_STAR      = 6'd7;
  localparam logic [5:0] KIND_SLASH     = 6'd8;
  localparam logic [5:0] KIND_AMP       = 6'd9;
  localparam logic [5:0] KIND_OR        = 6'd10;
  localparam logic [5:0] KIND_ASSIGN    = 6'd11;
  localparam logic [5:0] KIND_NOT       = 6'd13;
  localparam logic [5:0] KIND_LESS      = 6'd15;
  localparam logic [5:0] KIND_GREATER   = 6'd17;
  localparam logic [5:0] KIND_QUESTION  = 6'd19;
  localparam logic [5:0] KIND_COLON     = 6'd20;
  localparam logic [5:0] KIND_LPAREN    = 6'd21;
  localparam logic [5:0] KIND_RPAREN    = 6'd22;
  localparam logic [5:0] KIND_LBRACE    = 6'd23;
  localparam logic [5:0] KIND_RBRACE    = 6'd24;
  localparam logic [5:0] KIND_LBRACKET  = 6'd25;
  localparam logic [5:0] KIND_RBRACKET  = 6'd26;
  localparam logic [5:0] KIND_COMMA     = 6'd27;
  localparam logic [5:0] KIND_SEMI      = 6'd28;
  localparam logic [5:0] KIND_DOT       = 6'd29;
  localparam logic [5:0] KIND_XOR       = 6'd30;
  localparam logic [5:0] KIND_INVALID   = 6'd31;
  localparam logic [5:0] KIND_EOF       = 6'd32;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6E:   r = CH_LF;
      8'h74:   r = CH_TAB;
      8'h72:   r = CH_CR;
      8'h30:   r = CH_NUL;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h26:   k = KIND_AMP;
      8'h7C:   k = KIND_OR;
      8'h3F:   k = KIND_QUESTION;
      8'h3A:   k = KIND_COLON;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      8'h2E:   k = KIND_DOT;
      8'h5E:   k = KIND_XOR;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Kind of a pending two-character operator head; one more when '=' follows.
  function automatic logic [5:0] op2_kind(input logic [7:0] head);
    logic [5:0] k;
    unique case (head)
      CH_EQUAL: k = KIND_ASSIGN;
      CH_BANG:  k = KIND_NOT;
      CH_LESS:  k = KIND_LESS;
      default:  k = KIND_GREATER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/stt_fifo.sv */
// ----------------------------------------------------------------------------
// stt_fifo
// Two-entry queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      pop_data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/stt_front.sv */
// ----------------------------------------------------------------------------
// stt_front
// Lexer FSM: classifies one accepted byte per cycle into a result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
  parameter int unsigned PositionBits = stt_pkg::POS_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic [7:0]              source_byte_i,
  input  wire logic                    end_of_source_i,
  output logic                         push_o,
  output logic [stt_pkg::CNT_BITS-1:0] bundle_count_o,
  output logic [stt_pkg::MAX_RECS*(15+3*PositionBits)-1:0] bundle_recs_o
);

  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);

  typedef struct packed {
    logic                    rk;
    logic [7:0]              tb;
    logic [5:0]              kind;
    logic [PositionBits-1:0] ln;
    logic [PositionBits-1:0] col;
    logic [PositionBits-1:0] len;
  } rec_t;

  function automatic logic [PositionBits-1:0] sat_inc(input logic [PositionBits-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  function automatic rec_t mk_text(input logic [7:0] b);
    rec_t r;
    r    = '0;
    r.tb = b;
    return r;
  endfunction

  function automatic rec_t mk_end(input logic [5:0] k, input logic [PositionBits-1:0] ln,
                                  input logic [PositionBits-1:0] col,
                                  input logic [PositionBits-1:0] len);
    rec_t r;
    r      = '0;
    r.rk   = 1'b1;
    r.kind = k;
    r.ln   = ln;
    r.col  = col;
    r.len  = len;
    return r;
  endfunction

  stt_pkg::mode_e          mode_q, mode_d;
  logic                    esc_q, esc_d;
  logic [7:0]              cv_q, cv_d;
  logic [PositionBits-1:0] start_q, start_d;
  logic [PositionBits-1:0] bc_q, bc_d;
  logic [PositionBits-1:0] line_q, line_d;
  logic [PositionBits-1:0] col_q, col_d;
  rec_t [stt_pkg::MAX_RECS-1:0] recs;
  logic [stt_pkg::CNT_BITS-1:0] n;

  always_comb begin
    logic [7:0] c;
    logic       redo;
    logic       eos;
    c       = source_byte_i;
    eos     = (c == stt_pkg::CH_NUL) || end_of_source_i;
    redo    = 1'b0;
    mode_d  = mode_q;
    esc_d   = esc_q;
    cv_d    = cv_q;
    start_d = start_q;
    bc_d    = bc_q;
    line_d  = line_q;
    col_d   = col_q;
    recs    = '0;
    n       = '0;

    if (c != stt_pkg::CH_NUL) begin
      unique case (mode_q)
        stt_pkg::MODE_SLASH: begin
          if (c == stt_pkg::CH_SLASH) begin
            mode_d = stt_pkg::MODE_COMMENT;
          end else begin
            recs[n] = mk_text(stt_pkg::CH_SLASH); n = n + 1'b1; bc_d = sat_inc(bc_d);
            recs[n] = mk_end(stt_pkg::KIND_SLASH, line_d, start_d, bc_d); n = n + 1'b1;
            redo = 1'b1;
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (c == stt_pkg::CH_LF) mode_d = stt_pkg::MODE_IDLE;
        end
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else begin
            recs[n] = mk_end(stt_pkg::KIND_IDENT, line_d, start_d, bc_d); n = n + 1'b1;
            redo = 1'b1;
          end
        end
        stt_pkg::MODE_INT: begin
          if (stt_pkg::is_digit(c) || c == stt_pkg::CH_DOT) begin
            if (c == stt_pkg::CH_DOT) mode_d = stt_pkg::MODE_FLOAT;
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else begin
            recs[n] = mk_end(stt_pkg::KIND_INT, line_d, start_d, bc_d); n = n + 1'b1;
            redo = 1'b1;
          end
        end
        stt_pkg::MODE_FLOAT: begin
          if (stt_pkg::is_digit(c)) begin
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else begin
            recs[n] = mk_end(stt_pkg::KIND_FLOAT, line_d, start_d, bc_d); n = n + 1'b1;
            redo = 1'b1;
          end
        end
        stt_pkg::MODE_STRING: begin
          if (esc_d) begin
            esc_d = 1'b0;
            recs[n] = mk_text(stt_pkg::unescape(c)); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else if (c == stt_pkg::CH_BSLASH) begin
            esc_d = 1'b1;
          end else if (c == stt_pkg::CH_DQUOTE) begin
            recs[n] = mk_end(stt_pkg::KIND_STRING, line_d, start_d, bc_d); n = n + 1'b1;
            mode_d = stt_pkg::MODE_IDLE;
          end else begin
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end
        end
        stt_pkg::MODE_CHAR_OPEN: begin
          if (!esc_d && c == stt_pkg::CH_BSLASH) begin
            esc_d = 1'b1;
          end else begin
            cv_d  = esc_d ? stt_pkg::unescape(c) : c;
            esc_d = 1'b0;
            recs[n] = mk_text(cv_d); n = n + 1'b1; bc_d = sat_inc(bc_d);
            mode_d = stt_pkg::MODE_CHAR_CLOSE;
          end
        end
        stt_pkg::MODE_CHAR_CLOSE: begin
          recs[n] = mk_end(stt_pkg::KIND_CHAR, line_d, start_d, bc_d); n = n + 1'b1;
          if (c == stt_pkg::CH_SQUOTE) begin
            mode_d = stt_pkg::MODE_IDLE;
          end else begin
            redo = 1'b1;
          end
        end
        stt_pkg::MODE_OP2: begin
          if (c == stt_pkg::CH_EQUAL) begin
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
            recs[n] = mk_end(stt_pkg::op2_kind(cv_d) + 6'd1, line_d, start_d, bc_d);
            n = n + 1'b1;
            mode_d = stt_pkg::MODE_IDLE;
          end else begin
            recs[n] = mk_end(stt_pkg::op2_kind(cv_d), line_d, start_d, bc_d); n = n + 1'b1;
            redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase

      // A byte that did not continue the pending token starts afresh.
      if (redo) begin
        mode_d = stt_pkg::MODE_IDLE;
        if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB || c == stt_pkg::CH_CR ||
            c == stt_pkg::CH_LF) begin
          mode_d = stt_pkg::MODE_IDLE;
        end else begin
          start_d = col_d;
          bc_d    = '0;
          esc_d   = 1'b0;
          if (c == stt_pkg::CH_SLASH) begin
            mode_d = stt_pkg::MODE_SLASH;
          end else if (stt_pkg::is_alpha(c)) begin
            mode_d = stt_pkg::MODE_IDENT;
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else if (stt_pkg::is_digit(c)) begin
            mode_d = stt_pkg::MODE_INT;
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else if (c == stt_pkg::CH_DQUOTE) begin
            mode_d = stt_pkg::MODE_STRING;
          end else if (c == stt_pkg::CH_SQUOTE) begin
            mode_d = stt_pkg::MODE_CHAR_OPEN;
          end else if (c == stt_pkg::CH_EQUAL || c == stt_pkg::CH_BANG ||
                       c == stt_pkg::CH_LESS || c == stt_pkg::CH_GREAT) begin
            mode_d = stt_pkg::MODE_OP2;
            cv_d   = c;
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
          end else begin
            mode_d = stt_pkg::MODE_IDLE;
            recs[n] = mk_text(c); n = n + 1'b1; bc_d = sat_inc(bc_d);
            recs[n] = mk_end(stt_pkg::single_kind(c), line_d, start_d, bc_d); n = n + 1'b1;
          end
        end
      end

      // Every consumed byte moves the position; a newline starts a new line.
      if (c == stt_pkg::CH_LF) begin
        line_d = sat_inc(line_d);
        col_d  = PosOne;
      end else begin
        col_d = sat_inc(col_d);
      end
    end

    if (eos) begin
      unique case (mode_d)
        stt_pkg::MODE_SLASH: begin
          recs[n] = mk_text(stt_pkg::CH_SLASH); n = n + 1'b1; bc_d = sat_inc(bc_d);
          recs[n] = mk_end(stt_pkg::KIND_SLASH, line_d, start_d, bc_d); n = n + 1'b1;
        end
        stt_pkg::MODE_IDENT: begin
          recs[n] = mk_end(stt_pkg::KIND_IDENT, line_d, start_d, bc_d); n = n + 1'b1;
        end
        stt_pkg::MODE_INT: begin
          recs[n] = mk_end(stt_pkg::KIND_INT, line_d, start_d, bc_d); n = n + 1'b1;
        end
        stt_pkg::MODE_FLOAT: begin
          recs[n] = mk_end(stt_pkg::KIND_FLOAT, line_d, start_d, bc_d); n = n + 1'b1;
        end
        stt_pkg::MODE_STRING: begin
          recs[n] = mk_end(stt_pkg::KIND_STRING, line_d, start_d, bc_d); n = n + 1'b1;
        end
        stt_pkg::MODE_CHAR_OPEN, stt_pkg::MODE_CHAR_CLOSE: begin
          recs[n] = mk_end(stt_pkg::KIND_CHAR, line_d, start_d, bc_d); n = n + 1'b1;
        end
        stt_pkg::MODE_OP2: begin
          recs[n] = mk_end(stt_pkg::op2_kind(cv_d), line_d, start_d, bc_d); n = n + 1'b1;
        end
        default: n = n;
      endcase
      recs[n] = mk_end(stt_pkg::KIND_EOF, line_d, col_d, '0); n = n + 1'b1;
      mode_d  = stt_pkg::MODE_IDLE;
      esc_d   = 1'b0;
      cv_d    = '0;
      start_d = PosOne;
      bc_d    = '0;
      line_d  = PosOne;
      col_d   = PosOne;
    end
  end

  assign push_o         = accept_i && (n != '0);
  assign bundle_count_o = n;
  assign bundle_recs_o  = recs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      esc_q   <= 1'b0;
      cv_q    <= '0;
      start_q <= PosOne;
      bc_q    <= '0;
      line_q  <= PosOne;
      col_q   <= PosOne;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      cv_q    <= cv_d;
      start_q <= start_d;
      bc_q    <= bc_d;
      line_q  <= line_d;
      col_q   <= col_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/stt_back.sv */
// ----------------------------------------------------------------------------
// stt_back
// Holds one result bundle; hands out one record per cycle unless out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back #(
  parameter int unsigned PositionBits = stt_pkg::POS_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire logic [stt_pkg::CNT_BITS-1:0] q_count_i,
  input  wire logic [stt_pkg::MAX_RECS*(15+3*PositionBits)-1:0] q_recs_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         record_kind_o,
  output logic [7:0]                   text_byte_o,
  output logic [5:0]                   token_kind_o,
  output logic [PositionBits-1:0]      token_line_o,
  output logic [PositionBits-1:0]      token_column_o,
  output logic [PositionBits-1:0]      token_length_o,
  output logic                         last_of_run_o
);

  typedef struct packed {
    logic                    rk;
    logic [7:0]              tb;
    logic [5:0]              kind;
    logic [PositionBits-1:0] ln;
    logic [PositionBits-1:0] col;
    logic [PositionBits-1:0] len;
  } rec_t;

  rec_t [stt_pkg::MAX_RECS-1:0] recs_q;
  logic [stt_pkg::CNT_BITS-1:0] count_q;
  logic [stt_pkg::CNT_BITS-1:0] idx_q, idx_d;
  logic                         busy_q, busy_d;
  logic                         last, done;
  rec_t                         cur;

  assign cur         = recs_q[idx_q];
  assign last        = idx_q == count_q - 1'b1;
  assign done        = busy_q && !out_stall_i && last;
  assign q_pop_o     = !q_empty_i && (!busy_q || done);
  assign out_valid_o = busy_q;

  assign record_kind_o  = cur.rk;
  assign text_byte_o    = cur.tb;
  assign token_kind_o   = cur.kind;
  assign token_line_o   = cur.ln;
  assign token_column_o = cur.col;
  assign token_length_o = cur.len;
  assign last_of_run_o  = last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && !out_stall_i) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      recs_q  <= q_recs_i;
      count_q <= q_count_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/source_text_tokenizer.sv */
// A result is registered in a queue entry and then in the back part's bundle register.
// Throughput: one byte per cycle at the input while the queue is not full; the output
// gives one record per cycle while out_stall_i is low; a byte gives at most six records.
// A two-entry bundle queue between the lexer and the output sequencer absorbs bursts.
// Reset (rst_ni low, asynchronous) puts the lexer between tokens at line 1, column 1,
// and empties the queue and the output stage.
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: bytes in, token text and token end records out.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
  parameter int unsigned PositionBits = stt_pkg::POS_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              source_byte_i,
  input  wire logic                    end_of_source_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         record_kind_o,
  output logic [7:0]                   text_byte_o,
  output logic [5:0]                   token_kind_o,
  output logic [PositionBits-1:0]      token_line_o,
  output logic [PositionBits-1:0]      token_column_o,
  output logic [PositionBits-1:0]      token_length_o,
  output logic                         last_of_run_o
);

  localparam int unsigned RecsW  = stt_pkg::MAX_RECS * (15 + 3 * PositionBits);
  localparam int unsigned EntryW = RecsW + stt_pkg::CNT_BITS;

  logic                         accept;
  logic                         push, full, empty, pop;
  logic [stt_pkg::CNT_BITS-1:0] f_count, q_count;
  logic [RecsW-1:0]             f_recs, q_recs;

  // The input is held off only while both queue entries are occupied. Bytes
  // that yield no record (blanks, comments) still advance the lexer state.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  stt_front #(.PositionBits(PositionBits)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .source_byte_i   (source_byte_i),
    .end_of_source_i (end_of_source_i),
    .push_o          (push),
    .bundle_count_o  (f_count),
    .bundle_recs_o   (f_recs)
  );

  stt_fifo #(.Width(EntryW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_count, f_recs}),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  ({q_count, q_recs})
  );

  // The back part walks the records of one bundle and flags the final one.
  stt_back #(.PositionBits(PositionBits)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (empty),
    .q_count_i      (q_count),
    .q_recs_i       (q_recs),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .record_kind_o  (record_kind_o),
    .text_byte_o    (text_byte_o),
    .token_kind_o   (token_kind_o),
    .token_line_o   (token_line_o),
    .token_column_o (token_column_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

/* bench/tb_source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer
// Drives source bytes into the tokenizer and checks every text and end record
// against a behavioral predictor of the lexer kept inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_source_text_tokenizer;

  localparam int PB = 16;
  localparam logic [PB-1:0] POS_SAT = '1;
  localparam logic [PB-1:0] POS_ONE = PB'(1);
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic          rk;
    logic [7:0]    tb;
    logic [5:0]    kind;
    logic [PB-1:0] ln;
    logic [PB-1:0] col;
    logic [PB-1:0] len;
    logic          last;
  } record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] source_byte_i = '0;
  logic end_of_source_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic record_kind_o;
  logic [7:0] text_byte_o;
  logic [5:0] token_kind_o;
  logic [PB-1:0] token_line_o, token_column_o, token_length_o;
  logic last_of_run_o;

  source_text_tokenizer #(.PositionBits(PB)) dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // Predictor state, a copy of the lexer's registers.
  stt_pkg::mode_e lx_mode;
  logic          lx_esc;
  logic [7:0]    lx_head;
  logic [PB-1:0] lx_start, lx_count, lx_line, lx_col;
  record_t       pending_records[$];
  record_t       step_recs[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            calm = 1'b0;

  function automatic logic [PB-1:0] sat_up(logic [PB-1:0] v);
    return (v == POS_SAT) ? v : v + 1'b1;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == stt_pkg::CH_UNDER;
  endfunction

  function automatic bit numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] decode_escape(logic [7:0] c);
    case (c)
      "n": return stt_pkg::CH_LF;
      "t": return stt_pkg::CH_TAB;
      "r": return stt_pkg::CH_CR;
      "0": return stt_pkg::CH_NUL;
      default: return c;
    endcase
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    case (c)
      "+": return stt_pkg::KIND_PLUS;
      "-": return stt_pkg::KIND_MINUS;
      "*": return stt_pkg::KIND_STAR;
      "&": return stt_pkg::KIND_AMP;
      "|": return stt_pkg::KIND_OR;
      "?": return stt_pkg::KIND_QUESTION;
      ":": return stt_pkg::KIND_COLON;
      "(": return stt_pkg::KIND_LPAREN;
      ")": return stt_pkg::KIND_RPAREN;
      "{": return stt_pkg::KIND_LBRACE;
      "}": return stt_pkg::KIND_RBRACE;
      "[": return stt_pkg::KIND_LBRACKET;
      "]": return stt_pkg::KIND_RBRACKET;
      ",": return stt_pkg::KIND_COMMA;
      ";": return stt_pkg::KIND_SEMI;
      ".": return stt_pkg::KIND_DOT;
      "^": return stt_pkg::KIND_XOR;
      default: return stt_pkg::KIND_INVALID;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(logic [7:0] h);
    case (h)
      stt_pkg::CH_EQUAL: return stt_pkg::KIND_ASSIGN;
      stt_pkg::CH_BANG:  return stt_pkg::KIND_NOT;
      stt_pkg::CH_LESS:  return stt_pkg::KIND_LESS;
      default:           return stt_pkg::KIND_GREATER;
    endcase
  endfunction

  function automatic void lexer_clear();
    lx_mode = stt_pkg::MODE_IDLE; lx_esc = 1'b0; lx_head = '0;
    lx_start = POS_ONE; lx_count = '0; lx_line = POS_ONE; lx_col = POS_ONE;
  endfunction

  function automatic void add_rec(logic rk, logic [7:0] tb, logic [5:0] k,
                                  logic [PB-1:0] ln, logic [PB-1:0] col, logic [PB-1:0] len);
    record_t r;
    r = '{rk, tb, k, ln, col, len, 1'b0};
    if (step_recs.size() < stt_pkg::MAX_RECS) step_recs = {step_recs, r};
  endfunction

  function automatic void emit_text(logic [7:0] b);
    add_rec(1'b0, b, '0, '0, '0, '0);
    lx_count = sat_up(lx_count);
  endfunction

  function automatic void emit_end(logic [5:0] k);
    add_rec(1'b1, '0, k, lx_line, lx_start, lx_count);
  endfunction

  function automatic void advance(logic [7:0] c);
    if (c == stt_pkg::CH_LF) begin
      lx_line = sat_up(lx_line);
      lx_col = POS_ONE;
    end else begin
      lx_col = sat_up(lx_col);
    end
  endfunction

  function automatic void open_token(stt_pkg::mode_e m);
    lx_start = lx_col; lx_count = '0; lx_esc = 1'b0; lx_mode = m;
  endfunction

  function automatic void lex_fresh(logic [7:0] c);
    if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB || c == stt_pkg::CH_CR ||
        c == stt_pkg::CH_LF) begin
      // Blanks only move the position.
    end else if (c == stt_pkg::CH_SLASH) begin
      open_token(stt_pkg::MODE_SLASH);
    end else if (letter(c)) begin
      open_token(stt_pkg::MODE_IDENT); emit_text(c);
    end else if (numeral(c)) begin
      open_token(stt_pkg::MODE_INT); emit_text(c);
    end else if (c == stt_pkg::CH_DQUOTE) begin
      open_token(stt_pkg::MODE_STRING);
    end else if (c == stt_pkg::CH_SQUOTE) begin
      open_token(stt_pkg::MODE_CHAR_OPEN);
    end else if (c == stt_pkg::CH_EQUAL || c == stt_pkg::CH_BANG ||
                 c == stt_pkg::CH_LESS || c == stt_pkg::CH_GREAT) begin
      open_token(stt_pkg::MODE_OP2); lx_head = c; emit_text(c);
    end else begin
      open_token(stt_pkg::MODE_IDLE); emit_text(c); emit_end(punct_kind(c));
    end
    advance(c);
  endfunction

  // One byte against the current mode. A token that ends without taking the
  // byte hands it back to the idle lexer.
  function automatic void lex_one(logic [7:0] c);
    bit relex;
    relex = 1'b0;
    case (lx_mode)
      stt_pkg::MODE_SLASH: begin
        if (c == stt_pkg::CH_SLASH) begin
          lx_mode = stt_pkg::MODE_COMMENT; advance(c);
        end else begin
          emit_text(stt_pkg::CH_SLASH); emit_end(stt_pkg::KIND_SLASH); relex = 1'b1;
        end
      end
      stt_pkg::MODE_COMMENT: begin
        if (c == stt_pkg::CH_LF) lx_mode = stt_pkg::MODE_IDLE;
        advance(c);
      end
      stt_pkg::MODE_IDENT: begin
        if (letter(c) || numeral(c)) begin
          emit_text(c); advance(c);
        end else begin
          emit_end(stt_pkg::KIND_IDENT); relex = 1'b1;
        end
      end
      stt_pkg::MODE_INT: begin
        if (numeral(c) || c == stt_pkg::CH_DOT) begin
          if (c == stt_pkg::CH_DOT) lx_mode = stt_pkg::MODE_FLOAT;
          emit_text(c); advance(c);
        end else begin
          emit_end(stt_pkg::KIND_INT); relex = 1'b1;
        end
      end
      stt_pkg::MODE_FLOAT: begin
        if (numeral(c)) begin
          emit_text(c); advance(c);
        end else begin
          emit_end(stt_pkg::KIND_FLOAT); relex = 1'b1;
        end
      end
      stt_pkg::MODE_STRING: begin
        if (lx_esc) begin
          lx_esc = 1'b0; emit_text(decode_escape(c));
        end else if (c == stt_pkg::CH_BSLASH) begin
          lx_esc = 1'b1;
        end else if (c == stt_pkg::CH_DQUOTE) begin
          emit_end(stt_pkg::KIND_STRING); lx_mode = stt_pkg::MODE_IDLE;
        end else begin
          emit_text(c);
        end
        advance(c);
      end
      stt_pkg::MODE_CHAR_OPEN: begin
        if (!lx_esc && c == stt_pkg::CH_BSLASH) begin
          lx_esc = 1'b1;
        end else begin
          lx_head = lx_esc ? decode_escape(c) : c;
          lx_esc = 1'b0; emit_text(lx_head); lx_mode = stt_pkg::MODE_CHAR_CLOSE;
        end
        advance(c);
      end
      stt_pkg::MODE_CHAR_CLOSE: begin
        emit_end(stt_pkg::KIND_CHAR);
        if (c == stt_pkg::CH_SQUOTE) begin
          lx_mode = stt_pkg::MODE_IDLE; advance(c);
        end else begin
          relex = 1'b1;
        end
      end
      stt_pkg::MODE_OP2: begin
        if (c == stt_pkg::CH_EQUAL) begin
          emit_text(c); emit_end(pair_kind(lx_head) + 6'd1);
          lx_mode = stt_pkg::MODE_IDLE; advance(c);
        end else begin
          emit_end(pair_kind(lx_head)); relex = 1'b1;
        end
      end
      default: lex_fresh(c);
    endcase
    if (relex) begin
      lx_mode = stt_pkg::MODE_IDLE;
      lex_fresh(c);
    end
  endfunction

  function automatic void flush_token();
    case (lx_mode)
      stt_pkg::MODE_SLASH: begin
        emit_text(stt_pkg::CH_SLASH); emit_end(stt_pkg::KIND_SLASH);
      end
      stt_pkg::MODE_IDENT: emit_end(stt_pkg::KIND_IDENT);
      stt_pkg::MODE_INT: emit_end(stt_pkg::KIND_INT);
      stt_pkg::MODE_FLOAT: emit_end(stt_pkg::KIND_FLOAT);
      stt_pkg::MODE_STRING: emit_end(stt_pkg::KIND_STRING);
      stt_pkg::MODE_CHAR_OPEN, stt_pkg::MODE_CHAR_CLOSE: emit_end(stt_pkg::KIND_CHAR);
      stt_pkg::MODE_OP2: emit_end(pair_kind(lx_head));
      default: ;
    endcase
    lx_mode = stt_pkg::MODE_IDLE;
  endfunction

  // Predicts the records one byte causes and queues them for the checker.
  function automatic void predict_byte(logic [7:0] c, logic eos);
    step_recs.delete();
    if (c != stt_pkg::CH_NUL) lex_one(c);
    if (c == stt_pkg::CH_NUL || eos) begin
      flush_token();
      add_rec(1'b1, '0, stt_pkg::KIND_EOF, lx_line, lx_col, '0);
      lexer_clear();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    pending_records = {pending_records, step_recs};
  endfunction

  // Sends one byte; the prediction is made when the byte is accepted.
  task automatic send_byte(logic [7:0] c, logic eos = 1'b0);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_byte_i <= c;
    end_of_source_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(c, eos);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver backpressure in bursts.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Result checker: every accepted record against the oldest expectation.
  always @(posedge clk_i) begin
    record_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{record_kind_o, text_byte_o, token_kind_o, token_line_o,
              token_column_o, token_length_o, last_of_run_o};
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %p", got);
      end else begin
        want = pending_records.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("record mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_identifiers_and_numbers();
    send_text("ab_Z9 _x 0123 45.67 8. 1.2.3");
    send_byte("\n");
  endtask

  task automatic test_operators();
    send_text("+-*&|?:(){}[],;.^ = == != ! <= < >= > =");
    send_byte("\n", 1'b0);
  endtask

  task automatic test_comments_and_slash();
    send_text("a/b // comment ; \"x\n\t\r/");
    send_byte(stt_pkg::CH_NUL);               // lone slash at the end
  endtask

  task automatic test_literals();
    send_text("\"hi\\n\\t\\r\\0\\\\\\\"\\q\" 'a' '\\n' '\\'' \"l1\nl2\" 'bc");
    send_text("'x");
    send_byte("\n");
    send_text("\"open\\");
    send_byte("'", 1'b1);                     // unterminated string, end marked
    send_byte(stt_pkg::CH_SQUOTE);
    send_byte(stt_pkg::CH_NUL);               // char quote with no value
    send_byte(8'h01); send_byte(8'h80); send_byte(8'hFF); send_byte("@");
    send_byte("x", 1'b1);
  endtask

  // Mostly well-formed token soup with random content, plus raw noise.
  task automatic test_random_text(int count);
    string pieces[$];
    logic [7:0] c;
    pieces = {"id", "x1", "42", "3.14", "\"s\\n\"", "'c'", "'\\t'", "==", "!=", "<=",
              ">", "//c\n", "/", "+", ";", " ", "\n", "\t"};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        send_text(pieces[$urandom_range(0, pieces.size() - 1)]);
      end else begin
        c = 8'($urandom_range(0, 255));
        if (c == stt_pkg::CH_NUL && $urandom_range(0, 3) != 0) c = "a";
        send_byte(c, $urandom_range(0, 40) == 0);
      end
    end
  endtask

  initial begin
    lexer_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identifiers_and_numbers();
    test_operators();
    test_comments_and_slash();
    test_literals();
    test_random_text(28);
    calm = 1'b1;
    test_random_text(12);
    send_byte(stt_pkg::CH_NUL);
    drop_valid();
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
